>>> rtl/pfxcr_pkg.sv
// ----------------------------------------------------------------------------
// pfxcr_pkg
// operation codes, decoded control bundle and helpers for the fixed-point unit
// ----------------------------------------------------------------------------
package pfxcr_pkg;

  typedef enum logic [5:0] {
    OP_ADDI = 6'd0, OP_ADDIS = 6'd1, OP_ORI = 6'd2, OP_ORIS = 6'd3,
    OP_XORI = 6'd4, OP_XORIS = 6'd5, OP_ANDI = 6'd6, OP_ANDIS = 6'd7,
    OP_ADD = 6'd8, OP_SUBF = 6'd9, OP_AND = 6'd10, OP_ANDC = 6'd11,
    OP_OR = 6'd12, OP_ORC = 6'd13, OP_XOR = 6'd14, OP_EQV = 6'd15,
    OP_NAND = 6'd16, OP_NOR = 6'd17, OP_NEG = 6'd18, OP_EXTSB = 6'd19,
    OP_EXTSH = 6'd20, OP_EXTSW = 6'd21, OP_CMP = 6'd22, OP_CMPL = 6'd23,
    OP_CMPI = 6'd24, OP_CMPLI = 6'd25, OP_RLWINM = 6'd26, OP_RLWIMI = 6'd27,
    OP_RLWNM = 6'd28, OP_CNTLZW = 6'd29, OP_CNTLZD = 6'd30, OP_CRAND = 6'd31,
    OP_CRANDC = 6'd32, OP_CREQV = 6'd33, OP_CRNAND = 6'd34, OP_CRNOR = 6'd35,
    OP_CROR = 6'd36, OP_CRORC = 6'd37, OP_CRXOR = 6'd38, OP_MCRF = 6'd39,
    OP_MCRXR = 6'd40, OP_MFCR = 6'd41, OP_MTCRF = 6'd42, OP_MFXER = 6'd43,
    OP_MTXER = 6'd44
  } op_t;

  localparam logic [3:0] CR_LT = 4'h8;
  localparam logic [3:0] CR_GT = 4'h4;
  localparam logic [3:0] CR_EQ = 4'h2;

  // msb first, so action lands in the lowest bits of the beat
  typedef struct packed {
    logic        wide_compare;
    logic [2:0]  cr_src;
    logic [2:0]  cr_dest;
    logic        record;
    logic [4:0]  rot_amount;
    logic [4:0]  mask_end;
    logic [4:0]  mask_begin;
    logic [15:0] imm16;
    logic [4:0]  reg_b;
    logic [4:0]  reg_a;
    logic [4:0]  reg_d;
    logic [5:0]  action;
  } instr_t;

  typedef struct packed {
    logic        gpr_written;
    logic [4:0]  gpr_index;
    logic [63:0] gpr_value;
    logic [31:0] cr_value;
    logic [2:0]  xer_flags;
  } result_t;

  function automatic logic [31:0] cr_field_put(input logic [31:0] cr, input logic [2:0] f,
                                               input logic [3:0] nib);
    logic [31:0] r;
    r = cr;
    r[(7 - f) * 4 +: 4] = nib;
    return r;
  endfunction

  function automatic logic [6:0] lead_zeros64(input logic [63:0] v);
    logic [6:0] n;
    logic       hit;
    n = 7'd64;
    hit = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 7'(63 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/ppc_fixed_point_cr_unit_top.sv
// ----------------------------------------------------------------------------
// ppc_fixed_point_cr_unit_top
// fixed-point and condition-register execution unit, one instruction a beat
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)
// s_axis   in   action, reg_d, reg_a, reg_b, imm16, mask_begin, mask_end,
//               rot_amount, record, cr_dest, cr_src, wide_compare (60 of 64 bits)
// m_axis   out  gpr_written, gpr_index, gpr_value, cr_value, xer_flags (105 of 112 bits)
//
// register file read and instruction are registered when a beat is accepted,
// execute feeds the output register, or the skid slot while the output stalls
// one beat per cycle with the skid slot free; back-to-back writes forwarded to reads
// after reset a clearing pass zeroes the register file, input held off
// a single output register with a skid slot decouples the result stall
module ppc_fixed_point_cr_unit_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // instruction fields as listed above
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata    // result fields as listed above
);

  pfxcr_pkg::instr_t  in_ins, ex_ins;
  pfxcr_pkg::result_t res, out_res, skid_res;
  logic               ex_valid, skid_valid, busy, accept, adv;
  logic [63:0]        rd_s, rd_a, rd_b, op_s, op_a, op_b;
  logic [31:0]        cr;
  logic [2:0]         xer;

  assign in_ins = s_axis_tdata[59:0];
  // the execute stage moves whenever the skid slot is free
  assign adv = !skid_valid;
  assign s_axis_tready = adv && !busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  pfxcr_regfile u_rf (
    .clk(clk), .rst(rst), .rd_en(adv),
    .rd_addr_d(in_ins.reg_d), .rd_addr_a(in_ins.reg_a), .rd_addr_b(in_ins.reg_b),
    .rd_data_d(rd_s), .rd_data_a(rd_a), .rd_data_b(rd_b),
    .wr_en(ex_valid && adv && res.gpr_written), .wr_addr(res.gpr_index),
    .wr_data(res.gpr_value), .busy(busy)
  );

  logic        fwd_v;
  logic [4:0]  fwd_idx;
  logic [63:0] fwd_val;

  // forward the write of the instruction that executed before the one now in execute
  always_comb begin
    op_s = (fwd_v && fwd_idx == ex_ins.reg_d) ? fwd_val : rd_s;
    op_a = (fwd_v && fwd_idx == ex_ins.reg_a) ? fwd_val : rd_a;
    op_b = (fwd_v && fwd_idx == ex_ins.reg_b) ? fwd_val : rd_b;
  end

  pfxcr_execute u_ex (
    .ins(ex_ins), .s(op_s), .a(op_a), .b(op_b), .cr(cr), .xer(xer), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
      cr <= '0;
      xer <= '0;
      fwd_v <= 1'b0;
    end else begin
      if (adv) begin
        ex_valid <= accept;
        ex_ins <= in_ins;
        fwd_v <= ex_valid && res.gpr_written;
        fwd_idx <= res.gpr_index;
        fwd_val <= res.gpr_value;
        if (ex_valid) begin
          cr <= res.cr_value;
          xer <= res.xer_flags;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (skid_valid) begin
          out_res <= skid_res;
          skid_valid <= 1'b0;
        end else if (adv && ex_valid) begin
          out_res <= res;
        end else begin
          m_axis_tvalid <= 1'b0;
        end
      end else if (adv && ex_valid) begin
        if (m_axis_tvalid) begin
          skid_res <= res;
          skid_valid <= 1'b1;
        end else begin
          out_res <= res;
          m_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  assign m_axis_tdata = {7'd0, out_res.xer_flags, out_res.cr_value, out_res.gpr_value,
                         out_res.gpr_index, out_res.gpr_written};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid) else $error("skid holds data without output");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input taken during clearing pass");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !s_axis_tready) else $error("input taken while skid full");

endmodule

>>> rtl/pfxcr_regfile.sv
// ----------------------------------------------------------------------------
// pfxcr_regfile
// 32x64 general register file, three read ports, one write port, with a
// clearing pass after reset
// ----------------------------------------------------------------------------
module pfxcr_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rd_addr_d,
  input  logic [4:0]  rd_addr_a,
  input  logic [4:0]  rd_addr_b,
  output logic [63:0] rd_data_d,
  output logic [63:0] rd_data_a,
  output logic [63:0] rd_data_b,
  input  logic        wr_en,
  input  logic [4:0]  wr_addr,
  input  logic [63:0] wr_data,
  output logic        busy
);

  logic [63:0] mem_d [32];
  logic [63:0] mem_a [32];
  logic [63:0] mem_b [32];
  logic [5:0]  clr_count;

  assign busy = !clr_count[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_count <= '0;
    end else if (busy) begin
      clr_count <= clr_count + 6'd1;
    end
  end

  // three copies of one store, one read port each
  always_ff @(posedge clk) begin
    if (busy) begin
      mem_d[clr_count[4:0]] <= '0;
      mem_a[clr_count[4:0]] <= '0;
      mem_b[clr_count[4:0]] <= '0;
    end else if (wr_en) begin
      mem_d[wr_addr] <= wr_data;
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_d <= mem_d[rd_addr_d];
      rd_data_a <= mem_a[rd_addr_a];
      rd_data_b <= mem_b[rd_addr_b];
    end
  end

endmodule

>>> rtl/pfxcr_execute.sv
// ----------------------------------------------------------------------------
// pfxcr_execute
// combinational execute of one instruction against operands, cr and xer
// ----------------------------------------------------------------------------
module pfxcr_execute (
  input  pfxcr_pkg::instr_t  ins,
  input  logic [63:0]        s,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  input  logic [31:0]        cr,
  input  logic [2:0]         xer,
  output pfxcr_pkg::result_t res
);

  logic [63:0] simm, imm, val, rhs, ca, cb;
  logic [31:0] crn, m, from, to, rot, s32;
  logic [4:0]  amt;
  logic [2:0]  xern;
  logic        wr, recd, x, y, r, lt, gt, logical;
  logic [4:0]  idx;
  logic [3:0]  nib;

  always_comb begin
    simm = {{48{ins.imm16[15]}}, ins.imm16};
    imm = {48'd0, ins.imm16};
    val = '0; wr = 1'b0; recd = 1'b0; idx = ins.reg_d;
    crn = cr; xern = xer;
    rhs = b; ca = '0; cb = '0; lt = 1'b0; gt = 1'b0; logical = 1'b0;
    x = cr[31 - ins.reg_a]; y = cr[31 - ins.reg_b]; r = 1'b0;
    from = 32'hFFFF_FFFF >> ins.mask_begin;
    to = 32'hFFFF_FFFF << (5'd31 - ins.mask_end);
    m = (ins.mask_begin <= ins.mask_end) ? (from & to) : (from | to);
    amt = (ins.action == pfxcr_pkg::OP_RLWNM) ? b[4:0] : ins.rot_amount;
    s32 = s[31:0];
    rot = (s32 << amt) | (s32 >> (6'd32 - {1'b0, amt}));
    nib = '0;
    case (ins.action)
      pfxcr_pkg::OP_ADDI, pfxcr_pkg::OP_ADDIS: begin
        val = ((ins.reg_a != 5'd0) ? a : 64'd0)
            + ((ins.action == pfxcr_pkg::OP_ADDIS) ? (simm << 16) : simm);
        wr = 1'b1;
      end
      pfxcr_pkg::OP_ORI, pfxcr_pkg::OP_ORIS: begin
        val = s | (ins.action[0] ? (imm << 16) : imm); wr = 1'b1; idx = ins.reg_a;
      end
      pfxcr_pkg::OP_XORI, pfxcr_pkg::OP_XORIS: begin
        val = s ^ (ins.action[0] ? (imm << 16) : imm); wr = 1'b1; idx = ins.reg_a;
      end
      pfxcr_pkg::OP_ANDI, pfxcr_pkg::OP_ANDIS: begin
        val = s & (ins.action[0] ? (imm << 16) : imm); wr = 1'b1; idx = ins.reg_a;
        recd = 1'b1;
      end
      pfxcr_pkg::OP_ADD: begin val = a + b; wr = 1'b1; recd = ins.record; end
      pfxcr_pkg::OP_SUBF: begin val = b - a; wr = 1'b1; recd = ins.record; end
      pfxcr_pkg::OP_NEG: begin val = 64'd0 - a; wr = 1'b1; recd = ins.record; end
      pfxcr_pkg::OP_AND, pfxcr_pkg::OP_ANDC, pfxcr_pkg::OP_OR, pfxcr_pkg::OP_ORC,
      pfxcr_pkg::OP_XOR, pfxcr_pkg::OP_EQV, pfxcr_pkg::OP_NAND, pfxcr_pkg::OP_NOR: begin
        case (ins.action)
          pfxcr_pkg::OP_AND:  val = s & b;
          pfxcr_pkg::OP_ANDC: val = s & ~b;
          pfxcr_pkg::OP_OR:   val = s | b;
          pfxcr_pkg::OP_ORC:  val = s | ~b;
          pfxcr_pkg::OP_XOR:  val = s ^ b;
          pfxcr_pkg::OP_EQV:  val = ~(s ^ b);
          pfxcr_pkg::OP_NAND: val = ~(s & b);
          default:            val = ~(s | b);
        endcase
        wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_EXTSB: begin
        val = {{56{s[7]}}, s[7:0]}; wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_EXTSH: begin
        val = {{48{s[15]}}, s[15:0]}; wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_EXTSW: begin
        val = {{32{s[31]}}, s[31:0]}; wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_CMP, pfxcr_pkg::OP_CMPL, pfxcr_pkg::OP_CMPI, pfxcr_pkg::OP_CMPLI: begin
        logical = (ins.action == pfxcr_pkg::OP_CMPL) || (ins.action == pfxcr_pkg::OP_CMPLI);
        if (ins.action == pfxcr_pkg::OP_CMPI) rhs = simm;
        else if (ins.action == pfxcr_pkg::OP_CMPLI) rhs = imm;
        if (!ins.wide_compare) begin
          ca = {32'd0, a[31:0] ^ {!logical, 31'd0}};
          cb = {32'd0, rhs[31:0] ^ {!logical, 31'd0}};
        end else begin
          ca = a ^ {!logical, 63'd0};
          cb = rhs ^ {!logical, 63'd0};
        end
        lt = ca < cb; gt = ca > cb;
        nib = (lt ? pfxcr_pkg::CR_LT : gt ? pfxcr_pkg::CR_GT : pfxcr_pkg::CR_EQ)
            | {3'd0, xer[2]};
        crn = pfxcr_pkg::cr_field_put(cr, ins.cr_dest, nib);
      end
      pfxcr_pkg::OP_RLWINM, pfxcr_pkg::OP_RLWIMI, pfxcr_pkg::OP_RLWNM: begin
        val = {32'd0, (rot & m) | ((ins.action == pfxcr_pkg::OP_RLWIMI) ?
                                   (a[31:0] & ~m) : 32'd0)};
        wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_CNTLZW: begin
        val = {57'd0, pfxcr_pkg::lead_zeros64({s[31:0], 32'hFFFF_FFFF})};
        wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_CNTLZD: begin
        val = {57'd0, pfxcr_pkg::lead_zeros64(s)};
        wr = 1'b1; idx = ins.reg_a; recd = ins.record;
      end
      pfxcr_pkg::OP_CRAND, pfxcr_pkg::OP_CRANDC, pfxcr_pkg::OP_CREQV,
      pfxcr_pkg::OP_CRNAND, pfxcr_pkg::OP_CRNOR, pfxcr_pkg::OP_CROR,
      pfxcr_pkg::OP_CRORC, pfxcr_pkg::OP_CRXOR: begin
        case (ins.action)
          pfxcr_pkg::OP_CRAND:  r = x & y;
          pfxcr_pkg::OP_CRANDC: r = x & !y;
          pfxcr_pkg::OP_CREQV:  r = x == y;
          pfxcr_pkg::OP_CRNAND: r = !(x & y);
          pfxcr_pkg::OP_CRNOR:  r = !(x | y);
          pfxcr_pkg::OP_CROR:   r = x | y;
          pfxcr_pkg::OP_CRORC:  r = x | !y;
          default:              r = x ^ y;
        endcase
        crn[31 - ins.reg_d] = r;
      end
      pfxcr_pkg::OP_MCRF:
        crn = pfxcr_pkg::cr_field_put(cr, ins.cr_dest, cr[(7 - ins.cr_src) * 4 +: 4]);
      pfxcr_pkg::OP_MCRXR: begin
        crn = pfxcr_pkg::cr_field_put(cr, ins.cr_dest, {xer, 1'b0});
        xern = '0;
      end
      pfxcr_pkg::OP_MFCR: begin val = {32'd0, cr}; wr = 1'b1; end
      pfxcr_pkg::OP_MTCRF: begin
        for (int f = 0; f < 8; f++) begin
          if (ins.imm16[7 - f]) crn[(7 - f) * 4 +: 4] = s[(7 - f) * 4 +: 4];
        end
      end
      pfxcr_pkg::OP_MFXER: begin val = {32'd0, xer, 29'd0}; wr = 1'b1; end
      pfxcr_pkg::OP_MTXER: xern = s[31:29];
      default: ;
    endcase
    if (recd) begin
      crn[31:28] = (val[63] ? pfxcr_pkg::CR_LT : (val != 64'd0) ? pfxcr_pkg::CR_GT :
                    pfxcr_pkg::CR_EQ) | {3'd0, xer[2]};
    end
    res.gpr_written = wr;
    res.gpr_index = wr ? idx : 5'd0;
    res.gpr_value = wr ? val : 64'd0;
    res.cr_value = crn;
    res.xer_flags = xern;
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives random and directed instruction beats into the fixed-point unit and
// checks every result beat against a behavioral model of the register file,
// condition register and xer summary bits
// ----------------------------------------------------------------------------
class result_board;
  bit [63:0] gpr[32];
  bit [31:0] cr;
  bit [2:0]  xer;
  bit [111:0] pending[$];
  int errors;

  function void clear();
    foreach (gpr[k]) gpr[k] = '0;
    cr = '0;
    xer = '0;
    pending.delete();
    errors = 0;
  endfunction

  function bit [3:0] field_of(bit [2:0] f);
    return cr[(7 - f) * 4 +: 4];
  endfunction

  function void set_field(bit [2:0] f, bit [3:0] nib);
    cr[(7 - f) * 4 +: 4] = nib;
  endfunction

  function bit [3:0] order_nib(bit lt, bit gt);
    return (lt ? pfxcr_pkg::CR_LT : gt ? pfxcr_pkg::CR_GT : pfxcr_pkg::CR_EQ)
           | {3'b0, xer[2]};
  endfunction

  function bit [63:0] lz(bit [63:0] v, int width);
    int n;
    n = 0;
    for (int i = width - 1; i >= 0; i--) begin
      if (v[i]) break;
      n++;
    end
    return 64'(n);
  endfunction

  function void note_instr(bit [63:0] beat);
    bit [5:0] op;
    bit [4:0] rd, ra, rb, mb, me, sh;
    bit [15:0] imm;
    bit rc, wide, wr, recd, x, y, r, lt, gt;
    bit [2:0] bf, bfa;
    bit [63:0] simm, s, a, b, val, rhs, ua, ub;
    bit [31:0] m, rot, w;
    bit [4:0] amt, idx;
    op = beat[5:0]; rd = beat[10:6]; ra = beat[15:11]; rb = beat[20:16];
    imm = beat[36:21]; mb = beat[41:37]; me = beat[46:42]; sh = beat[51:47];
    rc = beat[52]; bf = beat[55:53]; bfa = beat[58:56]; wide = beat[59];
    simm = {{48{imm[15]}}, imm};
    s = gpr[rd]; a = gpr[ra]; b = gpr[rb];
    wr = 0; recd = 0; idx = 0; val = 0;
    case (op)
      pfxcr_pkg::OP_ADDI, pfxcr_pkg::OP_ADDIS: begin
        val = (ra != 0 ? a : 64'd0) + (op == pfxcr_pkg::OP_ADDIS ? simm << 16 : simm);
        idx = rd; wr = 1;
      end
      pfxcr_pkg::OP_ORI, pfxcr_pkg::OP_ORIS, pfxcr_pkg::OP_XORI, pfxcr_pkg::OP_XORIS,
      pfxcr_pkg::OP_ANDI, pfxcr_pkg::OP_ANDIS: begin
        rhs = op[0] ? {32'd0, imm, 16'd0} : {48'd0, imm};
        if (op <= pfxcr_pkg::OP_ORIS) val = s | rhs;
        else if (op <= pfxcr_pkg::OP_XORIS) val = s ^ rhs;
        else begin
          val = s & rhs;
          recd = 1;
        end
        idx = ra; wr = 1;
      end
      pfxcr_pkg::OP_ADD, pfxcr_pkg::OP_SUBF, pfxcr_pkg::OP_NEG: begin
        val = op == pfxcr_pkg::OP_ADD ? a + b : op == pfxcr_pkg::OP_SUBF ? b - a : -a;
        idx = rd; wr = 1; recd = rc;
      end
      pfxcr_pkg::OP_AND, pfxcr_pkg::OP_ANDC, pfxcr_pkg::OP_OR, pfxcr_pkg::OP_ORC,
      pfxcr_pkg::OP_XOR, pfxcr_pkg::OP_EQV, pfxcr_pkg::OP_NAND, pfxcr_pkg::OP_NOR: begin
        case (op)
          pfxcr_pkg::OP_AND: val = s & b;
          pfxcr_pkg::OP_ANDC: val = s & ~b;
          pfxcr_pkg::OP_OR: val = s | b;
          pfxcr_pkg::OP_ORC: val = s | ~b;
          pfxcr_pkg::OP_XOR: val = s ^ b;
          pfxcr_pkg::OP_EQV: val = ~(s ^ b);
          pfxcr_pkg::OP_NAND: val = ~(s & b);
          default: val = ~(s | b);
        endcase
        idx = ra; wr = 1; recd = rc;
      end
      pfxcr_pkg::OP_EXTSB, pfxcr_pkg::OP_EXTSH, pfxcr_pkg::OP_EXTSW: begin
        if (op == pfxcr_pkg::OP_EXTSB) val = {{56{s[7]}}, s[7:0]};
        else if (op == pfxcr_pkg::OP_EXTSH) val = {{48{s[15]}}, s[15:0]};
        else val = {{32{s[31]}}, s[31:0]};
        idx = ra; wr = 1; recd = rc;
      end
      pfxcr_pkg::OP_CMP, pfxcr_pkg::OP_CMPL, pfxcr_pkg::OP_CMPI,
      pfxcr_pkg::OP_CMPLI: begin
        rhs = op == pfxcr_pkg::OP_CMPI ? simm :
              op == pfxcr_pkg::OP_CMPLI ? {48'd0, imm} : b;
        ua = a; ub = rhs;
        if (!wide) begin
          ua = {32'd0, a[31:0]}; ub = {32'd0, rhs[31:0]};
          if (op == pfxcr_pkg::OP_CMP || op == pfxcr_pkg::OP_CMPI) begin
            ua[31] = ~ua[31]; ub[31] = ~ub[31];
          end
        end else if (op == pfxcr_pkg::OP_CMP || op == pfxcr_pkg::OP_CMPI) begin
          ua[63] = ~ua[63]; ub[63] = ~ub[63];
        end
        lt = ua < ub; gt = ua > ub;
        set_field(bf, order_nib(lt, gt));
      end
      pfxcr_pkg::OP_RLWINM, pfxcr_pkg::OP_RLWIMI, pfxcr_pkg::OP_RLWNM: begin
        amt = op == pfxcr_pkg::OP_RLWNM ? b[4:0] : sh;
        m = mb <= me ? ((32'hFFFFFFFF >> mb) & (32'hFFFFFFFF << (31 - me)))
                     : ((32'hFFFFFFFF >> mb) | (32'hFFFFFFFF << (31 - me)));
        w = s[31:0];
        rot = (amt == 0) ? w : ((w << amt) | (w >> (32 - amt)));
        rot = rot & m;
        if (op == pfxcr_pkg::OP_RLWIMI) rot = rot | (a[31:0] & ~m);
        val = {32'd0, rot};
        idx = ra; wr = 1; recd = rc;
      end
      pfxcr_pkg::OP_CNTLZW, pfxcr_pkg::OP_CNTLZD: begin
        val = op == pfxcr_pkg::OP_CNTLZW ? lz({32'd0, s[31:0]}, 32) : lz(s, 64);
        idx = ra; wr = 1; recd = rc;
      end
      pfxcr_pkg::OP_CRAND, pfxcr_pkg::OP_CRANDC, pfxcr_pkg::OP_CREQV,
      pfxcr_pkg::OP_CRNAND, pfxcr_pkg::OP_CRNOR, pfxcr_pkg::OP_CROR,
      pfxcr_pkg::OP_CRORC, pfxcr_pkg::OP_CRXOR: begin
        x = cr[31 - ra]; y = cr[31 - rb];
        case (op)
          pfxcr_pkg::OP_CRAND: r = x & y;
          pfxcr_pkg::OP_CRANDC: r = x & ~y;
          pfxcr_pkg::OP_CREQV: r = x ~^ y;
          pfxcr_pkg::OP_CRNAND: r = ~(x & y);
          pfxcr_pkg::OP_CRNOR: r = ~(x | y);
          pfxcr_pkg::OP_CROR: r = x | y;
          pfxcr_pkg::OP_CRORC: r = x | ~y;
          default: r = x ^ y;
        endcase
        cr[31 - rd] = r;
      end
      pfxcr_pkg::OP_MCRF: set_field(bf, field_of(bfa));
      pfxcr_pkg::OP_MCRXR: begin
        set_field(bf, {xer, 1'b0});
        xer = 0;
      end
      pfxcr_pkg::OP_MFCR: begin
        val = {32'd0, cr}; idx = rd; wr = 1;
      end
      pfxcr_pkg::OP_MTCRF: begin
        for (int f = 0; f < 8; f++)
          if (imm[7 - f]) set_field(3'(f), s[(7 - f) * 4 +: 4]);
      end
      pfxcr_pkg::OP_MFXER: begin
        val = {32'd0, xer, 29'd0}; idx = rd; wr = 1;
      end
      pfxcr_pkg::OP_MTXER: xer = s[31:29];
      default: ;
    endcase
    if (wr) gpr[idx] = val;
    if (recd) set_field(0, order_nib(val[63], val != 0));
    pending.push_back({7'd0, xer, cr, val, wr ? idx : 5'd0, wr});
  endfunction

  task report_err(string what, bit [111:0] got, bit [111:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_result(bit [111:0] got);
    bit [111:0] want;
    if (pending.size() == 0) begin
      report_err("result beat with nothing expected", got, 112'd0);
      return;
    end
    want = pending.pop_front();
    if (got[0] != want[0]) report_err("gpr_written", 112'(got[0]), 112'(want[0]));
    if (got[5:1] != want[5:1])
      report_err("gpr_index", 112'(got[5:1]), 112'(want[5:1]));
    if (got[69:6] != want[69:6])
      report_err("gpr_value", 112'(got[69:6]), 112'(want[69:6]));
    if (got[101:70] != want[101:70])
      report_err("cr_value", 112'(got[101:70]), 112'(want[101:70]));
    if (got[104:102] != want[104:102])
      report_err("xer_flags", 112'(got[104:102]), 112'(want[104:102]));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [111:0] m_axis_tdata;

  result_board board;
  int cycles = 0;
  bit calm = 0;
  localparam int LIMIT = 400000;

  ppc_fixed_point_cr_unit_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // output side: check and random stall bursts
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19);
        m_axis_tready <= 0;
      end else m_axis_tready <= 1;
    end
  end

  task automatic send_instr(bit [63:0] beat);
    s_axis_tvalid <= 1;
    s_axis_tdata <= beat;
    do @(posedge clk); while (!s_axis_tready);
    board.note_instr(beat);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  function automatic bit [63:0] pack_instr(bit [5:0] op, bit [4:0] rd, bit [4:0] ra,
                                           bit [4:0] rb, bit [15:0] imm,
                                           bit [31:0] rest);
    return {4'd0, rest[22:0] & 23'h7FFFFF, imm, rb, ra, rd, op} & 64'h0FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic bit [63:0] rand_instr(bit [5:0] op);
    bit [63:0] v;
    v = {$urandom, $urandom};
    v[63:60] = 0;
    v[5:0] = op;
    return v;
  endfunction

  function automatic bit [5:0] pick_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 20) return pfxcr_pkg::OP_ADDIS + 6'($urandom_range(0, 6)) - 6'd1;
    if (k < 96) return 6'($urandom_range(0, 44));
    return 6'($urandom_range(45, 63));
  endfunction

  initial begin
    bit [63:0] v;
    board = new();
    board.clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extreme immediates, records, special codes
    send_instr(pack_instr(pfxcr_pkg::OP_ADDI, 5'd1, 5'd0, 5'd0, 16'hFFFF, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_ADDIS, 5'd2, 5'd1, 5'd0, 16'h8000, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_ADDI, 5'd3, 5'd0, 5'd0, 16'h7FFF, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_ORIS, 5'd3, 5'd4, 5'd0, 16'hFFFF, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_ANDI, 5'd4, 5'd5, 5'd0, 16'h0000, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_MTXER, 5'd4, 5'd0, 5'd0, 16'h0, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_MTXER, 5'd1, 5'd0, 5'd0, 16'h0, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_MFXER, 5'd6, 5'd0, 5'd0, 16'h0, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_ADD, 5'd7, 5'd1, 5'd2, 16'h0, 32'h0000_8000));
    send_instr(pack_instr(pfxcr_pkg::OP_CMPI, 5'd0, 5'd1, 5'd0, 16'h8000,
                          32'h0040_0000));
    send_instr(pack_instr(pfxcr_pkg::OP_CMP, 5'd0, 5'd2, 5'd3, 16'h0, 32'h0005_0000));
    send_instr(pack_instr(pfxcr_pkg::OP_MCRXR, 5'd0, 5'd0, 5'd0, 16'h0, 32'h0007_0000));
    send_instr(pack_instr(pfxcr_pkg::OP_RLWINM, 5'd1, 5'd8, 5'd0, 16'h0, 32'h007F_FFFF));
    send_instr(pack_instr(pfxcr_pkg::OP_RLWIMI, 5'd3, 5'd8, 5'd0, 16'h0, 32'h0000_03FF));
    send_instr(pack_instr(pfxcr_pkg::OP_CNTLZD, 5'd0, 5'd9, 5'd0, 16'h0, 32'h0000_8000));
    send_instr(pack_instr(pfxcr_pkg::OP_CNTLZW, 5'd1, 5'd9, 5'd0, 16'h0, 32'h0000_8000));
    send_instr(pack_instr(pfxcr_pkg::OP_CRNOR, 5'd31, 5'd0, 5'd31, 16'h0, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_MTCRF, 5'd1, 5'd0, 5'd0, 16'hFFFF, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_MCRF, 5'd0, 5'd0, 5'd0, 16'h0, 32'h0000_3800));
    send_instr(pack_instr(pfxcr_pkg::OP_MFCR, 5'd31, 5'd0, 5'd0, 16'h0, 0));
    send_instr(pack_instr(pfxcr_pkg::OP_EXTSB, 5'd1, 5'd10, 5'd0, 16'h0, 32'h0000_8000));
    send_instr(pack_instr(6'd63, 5'd31, 5'd31, 5'd31, 16'hFFFF, 32'h007F_FFFF));
    for (int n = 0; n < 1550; n++) begin
      if (n == 1380) calm = 1;
      v = rand_instr(pick_op());
      // seed registers with random low-word data now and then
      if ($urandom_range(0, 9) == 0) begin
        v = rand_instr(pfxcr_pkg::OP_ORIS);
        send_instr(v);
        v = rand_instr(pfxcr_pkg::OP_RLWIMI);
      end
      send_instr(v);
    end
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule

>>> files.f
rtl/pfxcr_pkg.sv
rtl/pfxcr_regfile.sv
rtl/pfxcr_execute.sv
rtl/ppc_fixed_point_cr_unit_top.sv
test/testbench.sv
